// File: sv/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_RADIX = 32;
    localparam int RADIX_W   = 6;
    localparam int DIGIT_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int ADDR_W    = $clog2(WORD_BITS);
    localparam int REM_W     = 7;

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_A     = 7'd65;
    localparam logic [CHAR_W-1:0] CH_NONE  = 7'd0;

    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    // floor(2^WORD_BITS / r), indexed by radix r; zero for r of 0 and 1
    localparam logic [WORD_BITS:0] TWO_POW_W = {1'b1, {WORD_BITS{1'b0}}};
    localparam int RECIP_N = 37;
    localparam logic [WORD_BITS-1:0] RECIP_TABLE [RECIP_N] = '{
        '0, '0,
        WORD_BITS'(TWO_POW_W / 2),  WORD_BITS'(TWO_POW_W / 3),
        WORD_BITS'(TWO_POW_W / 4),  WORD_BITS'(TWO_POW_W / 5),
        WORD_BITS'(TWO_POW_W / 6),  WORD_BITS'(TWO_POW_W / 7),
        WORD_BITS'(TWO_POW_W / 8),  WORD_BITS'(TWO_POW_W / 9),
        WORD_BITS'(TWO_POW_W / 10), WORD_BITS'(TWO_POW_W / 11),
        WORD_BITS'(TWO_POW_W / 12), WORD_BITS'(TWO_POW_W / 13),
        WORD_BITS'(TWO_POW_W / 14), WORD_BITS'(TWO_POW_W / 15),
        WORD_BITS'(TWO_POW_W / 16), WORD_BITS'(TWO_POW_W / 17),
        WORD_BITS'(TWO_POW_W / 18), WORD_BITS'(TWO_POW_W / 19),
        WORD_BITS'(TWO_POW_W / 20), WORD_BITS'(TWO_POW_W / 21),
        WORD_BITS'(TWO_POW_W / 22), WORD_BITS'(TWO_POW_W / 23),
        WORD_BITS'(TWO_POW_W / 24), WORD_BITS'(TWO_POW_W / 25),
        WORD_BITS'(TWO_POW_W / 26), WORD_BITS'(TWO_POW_W / 27),
        WORD_BITS'(TWO_POW_W / 28), WORD_BITS'(TWO_POW_W / 29),
        WORD_BITS'(TWO_POW_W / 30), WORD_BITS'(TWO_POW_W / 31),
        WORD_BITS'(TWO_POW_W / 32), WORD_BITS'(TWO_POW_W / 33),
        WORD_BITS'(TWO_POW_W / 34), WORD_BITS'(TWO_POW_W / 35),
        WORD_BITS'(TWO_POW_W / 36)
    };

    typedef struct packed {
        logic [WORD_BITS-1:0] quot;
        logic [DIGIT_W-1:0]   digit;
    } t_div_res;

    function automatic logic [WORD_BITS-1:0] recip(input logic [RADIX_W-1:0] r);
        logic [WORD_BITS-1:0] m;
        m = '0;
        if (int'(r) < RECIP_N) begin
            m = RECIP_TABLE[r];
        end
        return m;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_W'(10)) begin
            c = CH_A + CHAR_W'(d - DIGIT_W'(10));
        end else begin
            c = CH_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/itoa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if import itoa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic [RADIX_W-1:0]          radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              empty_res;

    modport source (output valid, output character, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input character, input last, input empty_res,
                    output ready);
endinterface

`default_nettype wire

// File: sv/itoa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/itoa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One digit step: quotient and remainder of a word by the radix, valid in the cycle
// after i_start. Reciprocal multiply, then a single correction.
module itoa_div_step import itoa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_dividend,
    input  wire logic [RADIX_W-1:0]   i_radix,
    output t_div_res                  o_res
);

    logic [2*WORD_BITS-1:0] r_prod;
    logic [REM_W-1:0]       r_x_low;
    logic [RADIX_W-1:0]     r_radix;

    logic [WORD_BITS-1:0]   q_hat;
    logic [2*REM_W-1:0]     back;
    logic [REM_W-1:0]       rem;
    logic [REM_W-1:0]       radix_ext;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod  <= {{WORD_BITS{1'b0}}, i_dividend} * {{WORD_BITS{1'b0}}, recip(i_radix)};
            r_x_low <= i_dividend[REM_W-1:0];
            r_radix <= i_radix;
        end
    end

    always_comb begin
        radix_ext = {1'b0, r_radix};
        q_hat     = r_prod[2*WORD_BITS-1:WORD_BITS];
        back      = {{REM_W{1'b0}}, q_hat[REM_W-1:0]} * {{REM_W{1'b0}}, radix_ext};
        rem       = r_x_low - back[REM_W-1:0];
        if (rem >= radix_ext) begin
            o_res.quot  = q_hat + WORD_BITS'(1);
            o_res.digit = DIGIT_W'(rem - radix_ext);
        end else begin
            o_res.quot  = q_hat;
            o_res.digit = DIGIT_W'(rem);
        end
    end

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_any_base_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// From accept, each digit takes a START and a STEP state (reciprocal divide),
// then each character a FETCH and a SEND state (RAM read); a leading minus is
// sent from S_MINUS before the digits. An invalid radix answers in the next
// cycle. A new item is accepted only in idle, after the last character of the
// previous one is taken.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
module integer_to_ascii_any_base_unit import itoa_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_START,
        S_STEP,
        S_MINUS,
        S_FETCH,
        S_SEND
    } t_state;

    t_state               r_state, n_state;
    logic [WORD_BITS-1:0] r_quot, n_quot;
    logic [RADIX_W-1:0]   r_radix, n_radix;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_minus, n_minus;

    t_div_res             div_res;
    logic                 div_start;
    logic                 ram_we;
    logic [DIGIT_W-1:0]   ram_q;
    logic [CNT_W-1:0]     cnt_m1;
    logic [WORD_BITS-1:0] in_bits;

    assign div_start = (r_state == S_START);
    assign ram_we    = (r_state == S_STEP) && (r_cnt < CNT_W'(WORD_BITS));
    assign cnt_m1    = r_cnt - CNT_W'(1);
    assign in_bits   = i_in.value;

    itoa_div_step u_div (
        .i_clk      (i_clk),
        .i_start    (div_start),
        .i_dividend (r_quot),
        .i_radix    (r_radix),
        .o_res      (div_res)
    );

    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (div_res.digit),
        .i_raddr (cnt_m1[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        o_out.valid     = 1'b0;
        o_out.character = CH_NONE;
        o_out.last      = 1'b0;
        o_out.empty_res = 1'b0;
        case (r_state)
            S_EMPTY: begin
                o_out.valid     = 1'b1;
                o_out.last      = 1'b1;
                o_out.empty_res = 1'b1;
            end
            S_MINUS: begin
                o_out.valid     = 1'b1;
                o_out.character = CH_MINUS;
            end
            S_SEND: begin
                o_out.valid     = 1'b1;
                o_out.character = digit_char(ram_q);
                o_out.last      = (r_cnt == CNT_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_radix = r_radix;
        n_cnt   = r_cnt;
        n_minus = r_minus;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.radix inside {[2:MAX_RADIX]}) begin
                        n_radix = i_in.radix;
                        n_cnt   = '0;
                        if (i_in.radix == RADIX_DEC && in_bits[WORD_BITS-1]) begin
                            n_minus = 1'b1;
                            n_quot  = WORD_BITS'(0) - in_bits;
                        end else begin
                            n_minus = 1'b0;
                            n_quot  = in_bits;
                        end
                        n_state = S_START;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_EMPTY: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (ram_we) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_quot = div_res.quot;
                if (div_res.quot == '0) begin
                    n_state = r_minus ? S_MINUS : S_FETCH;
                end else begin
                    n_state = S_START;
                end
            end
            S_MINUS: begin
                if (o_out.ready) begin
                    n_minus = 1'b0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (o_out.ready) begin
                    n_cnt   = cnt_m1;
                    n_state = (r_cnt == CNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_quot  <= '0;
            r_cnt   <= '0;
            r_minus <= 1'b0;
        end else begin
            r_state <= n_state;
            r_quot  <= n_quot;
            r_cnt   <= n_cnt;
            r_minus <= n_minus;
        end
        r_radix <= n_radix;
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import itoa_pkg::*;

    localparam int RAND_ITEMS = 300;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int CHOKE_LEN = 600;
    localparam int CHOKE_AT_A = 50;
    localparam int CHOKE_AT_B = 220;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic [RADIX_W-1:0]   radix;
    } t_conv_req;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
    } t_ascii_beat;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if  in_if ();
    itoa_out_if out_if ();

    integer_to_ascii_any_base_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_conv_req   pending_reqs [$];
    t_ascii_beat expected_chars [$];
    t_conv_req   tx_req;
    int          n_items;
    int          n_accepted;
    int          n_errors;
    int          tx_gap;
    logic        tx_steady;
    int          rx_stall;
    logic        rx_steady;
    int          choke_left;
    int          choke_idx;
    int          n_cycles;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Expected character stream for one conversion.
    function automatic void predict_text(input logic [WORD_BITS-1:0] val,
                                         input logic [RADIX_W-1:0] rdx);
        logic [WORD_BITS-1:0] mag;
        logic [DIGIT_W-1:0]   digs [WORD_BITS];
        logic                 neg;
        int                   n;
        int                   i;
        t_ascii_beat          beat;
        if (rdx < 2 || rdx > MAX_RADIX) begin
            beat = '{CH_NONE, 1'b1, 1'b1};
            expected_chars.push_back(beat);
            return;
        end
        neg = (rdx == RADIX_DEC) && val[WORD_BITS-1];
        mag = neg ? WORD_BITS'(-val) : val;
        n = 0;
        do begin
            digs[n] = DIGIT_W'(mag % rdx);
            mag = mag / rdx;
            n++;
        end while (mag != 0);
        if (neg) begin
            beat = '{CH_MINUS, 1'b0, 1'b0};
            expected_chars.push_back(beat);
        end
        for (i = n - 1; i >= 0; i--) begin
            if (digs[i] < 10) begin
                beat.ch = CHAR_W'(CH_ZERO + digs[i]);
            end else begin
                beat.ch = CHAR_W'(CH_A + digs[i] - 10);
            end
            beat.last  = (i == 0);
            beat.empty = 1'b0;
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic void add_req(input logic [WORD_BITS-1:0] val,
                                    input logic [RADIX_W-1:0] rdx);
        t_conv_req req;
        req.value = val;
        req.radix = rdx;
        pending_reqs.push_back(req);
    endfunction

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        in_if.radix = '0;
        out_if.ready = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stimulus and end of run
    initial begin
        int k;
        int sel;
        logic [WORD_BITS-1:0] v;
        logic [RADIX_W-1:0] r;

        add_req(32'd0, 6'd10);
        add_req(32'd0, 6'd2);
        add_req(32'hFFFF_FFFF, 6'd10);
        add_req(32'hFFFF_FFFF, 6'd2);
        add_req(32'hFFFF_FFFF, 6'd16);
        add_req(32'h8000_0000, 6'd10);
        add_req(32'h8000_0000, 6'd16);
        add_req(32'h7FFF_FFFF, 6'd10);
        add_req(32'h7FFF_FFFF, 6'd32);
        add_req(32'h7FFF_FFFF, 6'd2);
        add_req(32'hDEAD_BEEF, 6'd0);
        add_req(32'd7, 6'd1);
        add_req(32'h8000_0000, 6'd33);
        add_req(32'hFFFF_FFFF, 6'd63);
        add_req(32'd35, 6'd36);
        add_req(32'd12345, 6'd10);
        add_req(-32'sd12345, 6'd10);
        add_req(-32'sd12345, 6'd8);
        add_req(32'd31, 6'd32);
        add_req(32'hDEAD_BEEF, 6'd16);
        add_req(32'd9, 6'd10);
        add_req(32'd10, 6'd11);
        add_req(32'hFFFF_FFFF, 6'd3);
        add_req(32'd1, 6'd2);

        for (k = 0; k < RAND_ITEMS; k++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                4, 5: v = $urandom_range(0, 300);
                6: v = -$urandom_range(1, 300);
                7: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'd0;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h8000_0000;
                        3: v = 32'h7FFF_FFFF;
                        default: v = 32'd1;
                    endcase
                end
                8, 9: v = $urandom >> $urandom_range(0, 31);
                default: v = $urandom;
            endcase
            sel = $urandom_range(0, 19);
            case (sel)
                0, 1, 2: r = RADIX_DEC;
                3: r = 6'd16;
                4: r = 6'd2;
                5: r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                             : RADIX_W'($urandom_range(33, 63));
                default: r = RADIX_W'($urandom_range(2, 32));
            endcase
            add_req(v, r);
        end
        n_items = pending_reqs.size();

        @(posedge i_rst_n);
        while (n_accepted != n_items || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap      <= 0;
            tx_steady   <= 1'b0;
            n_accepted  <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_text(in_if.value, in_if.radix);
                n_accepted <= n_accepted + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap != 0) begin
                    tx_gap      <= tx_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    tx_req = pending_reqs.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.value <= tx_req.value;
                    in_if.radix <= tx_req.radix;
                    tx_gap      <= tx_steady ? 0 : pick_gap();
                    if ($urandom_range(0, 15) == 0) begin
                        tx_steady <= !tx_steady;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            choke_left <= 0;
            choke_idx  <= 0;
        end else if (choke_left != 0) begin
            choke_left <= choke_left - 1;
        end else if (choke_idx < 2 &&
                     n_accepted >= ((choke_idx == 0) ? CHOKE_AT_A : CHOKE_AT_B)) begin
            choke_left <= CHOKE_LEN;
            choke_idx  <= choke_idx + 1;
        end
    end

    // Output monitor and checker
    always @(posedge i_clk) begin
        t_ascii_beat want;
        int          bad;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall     <= 0;
            rx_steady    <= 1'b0;
            n_errors     <= 0;
        end else begin
            bad = 0;
            if (out_if.valid && out_if.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected item: char %0d last %0b empty %0b", $time,
                             out_if.character, out_if.last, out_if.empty_res);
                    bad++;
                end else begin
                    want = expected_chars.pop_front();
                    if (out_if.character !== want.ch) begin
                        $display("%0t: character: expected %0d, actual %0d", $time,
                                 want.ch, out_if.character);
                        bad++;
                    end
                    if (out_if.last !== want.last) begin
                        $display("%0t: last: expected %0b, actual %0b", $time,
                                 want.last, out_if.last);
                        bad++;
                    end
                    if (out_if.empty_res !== want.empty) begin
                        $display("%0t: empty_res: expected %0b, actual %0b", $time,
                                 want.empty, out_if.empty_res);
                        bad++;
                    end
                end
            end
            if (bad != 0) begin
                n_errors <= n_errors + bad;
            end
            if ($urandom_range(0, 63) == 0) begin
                rx_steady <= !rx_steady;
            end
            if (choke_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall     <= rx_stall - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) begin
                    rx_stall <= pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial n_cycles = 0;

endmodule
